/* rtl/cspa_pkg.sv */
// ----------------------------------------------------------------------------
// cspa_pkg
// Shared types and constants for the canary slot pool allocator.
// ----------------------------------------------------------------------------
package cspa_pkg;

   localparam int MAX_SLOTS   = 64;
   localparam int REGION_SIZE = 4096;

   localparam int CMD_W      = 2;
   localparam int OFF_W      = 12;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int USABLE_W   = 12;
   localparam int SLOT_CNT_W = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int ADDR_W     = $clog2(REGION_SIZE);
   localparam int SIZE_W     = USABLE_W + 1;
   localparam int EXT_W      = SIZE_W + 1;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int BASE_W     = SLOT_W + SIZE_W;
   localparam int FIT_W      = BASE_W + 1;
   localparam int ROW_BITS   = 8;
   localparam int ROWS       = MAX_SLOTS / ROW_BITS;
   localparam int ROW_PTR_W  = $clog2(ROWS);
   localparam int ROW_IDX_W  = $clog2(ROW_BITS);
   localparam int DIV_CNT_W  = $clog2(OFF_W + 1);

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CORRUPT   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_USABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD  = 2'd2;

   localparam logic [USABLE_W-1:0]   USABLE_RESET = 12'd15;
   localparam logic [SLOT_CNT_W-1:0] SLOTS_RESET  = 7'd64;
   localparam logic [BYTE_W-1:0]     GUARD_RESET  = 8'd165;

   typedef struct packed {
      logic             done;
      logic [OFF_W-1:0] quot;
      logic [OFF_W-1:0] rem;
   } cspa_div_rsp_type;

endpackage

/* rtl/cspa_ram.sv */
// ----------------------------------------------------------------------------
// cspa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cspa_div.sv */
// ----------------------------------------------------------------------------
// cspa_div
// Restoring divider, one quotient bit per cycle, for offset by slot size.
// ----------------------------------------------------------------------------
module cspa_div
   import cspa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [OFF_W-1:0]       dividend,
   input  logic [SIZE_W-1:0]      divisor,
   output cspa_div_rsp_type       rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [OFF_W-1:0]     dvd_ff, dvd_in;
   logic [OFF_W-1:0]     rem_ff, rem_in;
   logic [SIZE_W-1:0]    dsr_ff, dsr_in;
   logic [SIZE_W-1:0]    trial;
   logic [SIZE_W:0]      diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[OFF_W-1]};
      diff    = {1'b0, trial} - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(OFF_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[SIZE_W]) begin
            rem_in = diff[OFF_W-1:0];
            dvd_in = {dvd_ff[OFF_W-2:0], 1'b1};
         end else begin
            rem_in = trial[OFF_W-1:0];
            dvd_in = {dvd_ff[OFF_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = dvd_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* rtl/canary_slot_pool_allocator.sv */
// ----------------------------------------------------------------------------
// canary_slot_pool_allocator
// Fixed-slot pool allocator with a guard byte after every slot.
// Allocate scans the used map one 8-slot row at a time, reading and then checking
// each row. Free, write and read wait on the 12-step offset divider; a null free
// skips it and goes straight to the response state.
// One item is in work at a time; the next beat is taken in the cycle after the
// result loads, even while that result waits.
// Synchronous reset clears the used map valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module canary_slot_pool_allocator
   import cspa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [OFF_W-1:0]      req_byte_offset,
   input  logic [BYTE_W-1:0]     req_write_data,
   input  logic                  req_null_pointer,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [OFF_W-1:0]      rsp_slot_offset,
   output logic [BYTE_W-1:0]     rsp_read_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CHK = 4'd2;
   localparam logic [3:0] S_MUL      = 4'd3;
   localparam logic [3:0] S_FIT      = 4'd4;
   localparam logic [3:0] S_DIV      = 4'd5;
   localparam logic [3:0] S_FREE_CHK = 4'd6;
   localparam logic [3:0] S_RD_WAIT  = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [BYTE_W-1:0]     wdata_ff, wdata_in;
   logic [ROW_PTR_W-1:0]  row_ptr_ff, row_ptr_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [ROWS-1:0]       row_valid_ff, row_valid_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [OFF_W-1:0]      res_slot_ff, res_slot_in;
   logic [BYTE_W-1:0]     res_read_ff, res_read_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [BYTE_W-1:0]     rsp_read_ff, rsp_read_in;
   logic [USABLE_W-1:0]   usable_ff, usable_in;
   logic [SLOT_CNT_W-1:0] slots_ff, slots_in;
   logic [BYTE_W-1:0]     guard_ff, guard_in;

   logic [SIZE_W-1:0]     slot_span;
   logic [SLOT_CNT_W-1:0] live_n;
   logic [ROW_BITS-1:0]   scan_row;
   logic                  scan_found;
   logic [ROW_IDX_W-1:0]  scan_bit;
   logic [ROW_BITS-1:0]   free_row;
   logic                  q_in_pool;
   logic                  free_ok;
   logic                  access_ok;
   logic                  alloc_fits;

   logic                  div_start;
   cspa_div_rsp_type      div_rsp;

   logic                  used_wr_en;
   logic [ROW_PTR_W-1:0]  used_wr_addr;
   logic [ROW_BITS-1:0]   used_wr_data;
   logic                  used_rd_en;
   logic [ROW_PTR_W-1:0]  used_rd_addr;
   logic [ROW_BITS-1:0]   used_rd_data;

   logic                  reg_wr_en;
   logic [ADDR_W-1:0]     reg_wr_addr;
   logic [BYTE_W-1:0]     reg_wr_data;
   logic                  reg_rd_en;
   logic [ADDR_W-1:0]     reg_rd_addr;
   logic [BYTE_W-1:0]     reg_rd_data;

   cspa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_byte_offset),
      .divisor  (slot_span),
      .rsp      (div_rsp)
   );

   cspa_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_wr_en),
      .wr_addr (used_wr_addr),
      .wr_data (used_wr_data),
      .rd_en   (used_rd_en),
      .rd_addr (used_rd_addr),
      .rd_data (used_rd_data)
   );

   cspa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (REGION_SIZE)
   ) u_region_ram (
      .clock   (clock),
      .wr_en   (reg_wr_en),
      .wr_addr (reg_wr_addr),
      .wr_data (reg_wr_data),
      .rd_en   (reg_rd_en),
      .rd_addr (reg_rd_addr),
      .rd_data (reg_rd_data)
   );

   assign slot_span = {1'b0, usable_ff} + SIZE_W'(1);
   assign live_n    = (slots_ff > SLOT_CNT_W'(MAX_SLOTS)) ? SLOT_CNT_W'(MAX_SLOTS) : slots_ff;

   // A used-map row that was never written since reset reads as all free.
   assign scan_row = row_valid_ff[row_ptr_ff] ? used_rd_data : '0;
   assign free_row = row_valid_ff[slot_ff[SLOT_W-1:ROW_IDX_W]] ? used_rd_data : '0;

   always_comb begin
      scan_found = 1'b0;
      scan_bit   = '0;
      for (int k = ROW_BITS - 1; k >= 0; k--) begin
         if (!scan_row[k] &&
             (SLOT_CNT_W'({row_ptr_ff, ROW_IDX_W'(k)}) < live_n)) begin
            scan_found = 1'b1;
            scan_bit   = ROW_IDX_W'(k);
         end
      end
   end

   assign q_in_pool  = div_rsp.quot < OFF_W'(live_n);
   assign free_ok    = q_in_pool && (div_rsp.rem == '0) &&
                       ((EXT_W'(off_ff) + EXT_W'(slot_span)) <= EXT_W'(REGION_SIZE));
   assign access_ok  = q_in_pool &&
                       ((EXT_W'(off_ff) - EXT_W'(div_rsp.rem) + EXT_W'(slot_span))
                        <= EXT_W'(REGION_SIZE));
   assign alloc_fits = (FIT_W'(base_ff) + FIT_W'(slot_span)) <= FIT_W'(REGION_SIZE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      off_in        = off_ff;
      wdata_in      = wdata_ff;
      row_ptr_in    = row_ptr_ff;
      slot_in       = slot_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      row_valid_in  = row_valid_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_read_in   = res_read_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_read_in   = rsp_read_ff;
      usable_in     = usable_ff;
      slots_in      = slots_ff;
      guard_in      = guard_ff;
      div_start     = 1'b0;
      used_wr_en    = 1'b0;
      used_wr_addr  = slot_ff[SLOT_W-1:ROW_IDX_W];
      used_wr_data  = '0;
      used_rd_en    = 1'b0;
      used_rd_addr  = row_ptr_ff;
      reg_wr_en     = 1'b0;
      reg_wr_addr   = off_ff;
      reg_wr_data   = wdata_ff;
      reg_rd_en     = 1'b0;
      reg_rd_addr   = off_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_USABLE: usable_in = csr_data;
            CSR_SLOTS:  slots_in  = csr_data[SLOT_CNT_W-1:0];
            CSR_GUARD:  guard_in  = csr_data[BYTE_W-1:0];
            default:    ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               off_in        = req_byte_offset;
               wdata_in      = req_write_data;
               row_ptr_in    = '0;
               res_status_in = ST_OK;
               res_slot_in   = '0;
               res_read_in   = '0;
               if (req_command == CMD_ALLOC) begin
                  state_in = S_SCAN_RD;
               end else if (req_command == CMD_FREE && req_null_pointer) begin
                  state_in = S_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_SCAN_RD: begin
            used_rd_en   = 1'b1;
            used_rd_addr = row_ptr_ff;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (scan_found) begin
               slot_in  = {row_ptr_ff, scan_bit};
               row_in   = scan_row;
               state_in = S_MUL;
            end else if (row_ptr_ff == ROW_PTR_W'(ROWS - 1)) begin
               res_status_in = ST_EXHAUSTED;
               state_in      = S_RESP;
            end else begin
               row_ptr_in = row_ptr_ff + ROW_PTR_W'(1);
               state_in   = S_SCAN_RD;
            end
         end
         S_MUL: begin
            base_in  = BASE_W'(slot_ff) * BASE_W'(slot_span);
            state_in = S_FIT;
         end
         S_FIT: begin
            // Slots past the region end never fit, so the first free one decides.
            if (alloc_fits) begin
               used_wr_en   = 1'b1;
               used_wr_addr = slot_ff[SLOT_W-1:ROW_IDX_W];
               used_wr_data = row_ff | (ROW_BITS'(1) << slot_ff[ROW_IDX_W-1:0]);
               row_valid_in[slot_ff[SLOT_W-1:ROW_IDX_W]] = 1'b1;
               reg_wr_en    = 1'b1;
               reg_wr_addr  = base_ff[ADDR_W-1:0] + usable_ff;
               reg_wr_data  = guard_ff;
               res_slot_in  = base_ff[OFF_W-1:0];
            end else begin
               res_status_in = ST_EXHAUSTED;
            end
            state_in = S_RESP;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               slot_in = div_rsp.quot[SLOT_W-1:0];
               case (cmd_ff)
                  CMD_FREE: begin
                     if (free_ok) begin
                        used_rd_en   = 1'b1;
                        used_rd_addr = div_rsp.quot[SLOT_W-1:ROW_IDX_W];
                        reg_rd_en    = 1'b1;
                        reg_rd_addr  = off_ff + usable_ff;
                        state_in     = S_FREE_CHK;
                     end else begin
                        res_status_in = ST_INVALID;
                        state_in      = S_RESP;
                     end
                  end
                  CMD_WRITE, CMD_READ: begin
                     if (!access_ok) begin
                        res_status_in = ST_INVALID;
                        state_in      = S_RESP;
                     end else if (cmd_ff == CMD_WRITE) begin
                        reg_wr_en   = 1'b1;
                        reg_wr_addr = off_ff;
                        reg_wr_data = wdata_ff;
                        state_in    = S_RESP;
                     end else begin
                        reg_rd_en   = 1'b1;
                        reg_rd_addr = off_ff;
                        state_in    = S_RD_WAIT;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_FREE_CHK: begin
            if (!free_row[slot_ff[ROW_IDX_W-1:0]]) begin
               res_status_in = ST_DOUBLE;
            end else begin
               if (reg_rd_data != guard_ff) begin
                  res_status_in = ST_CORRUPT;
               end
               used_wr_en   = 1'b1;
               used_wr_addr = slot_ff[SLOT_W-1:ROW_IDX_W];
               used_wr_data = free_row & ~(ROW_BITS'(1) << slot_ff[ROW_IDX_W-1:0]);
               row_valid_in[slot_ff[SLOT_W-1:ROW_IDX_W]] = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RD_WAIT: begin
            res_read_in = reg_rd_data;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_read_in   = res_read_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         usable_ff    <= USABLE_RESET;
         slots_ff     <= SLOTS_RESET;
         guard_ff     <= GUARD_RESET;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         usable_ff    <= usable_in;
         slots_ff     <= slots_in;
         guard_ff     <= guard_in;
      end
      cmd_ff        <= cmd_in;
      off_ff        <= off_in;
      wdata_ff      <= wdata_in;
      row_ptr_ff    <= row_ptr_in;
      slot_ff       <= slot_in;
      row_ff        <= row_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_read_ff   <= res_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_read_ff   <= rsp_read_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_offset = rsp_slot_ff;
   assign rsp_read_data   = rsp_read_ff;

   // A new result beat appears only out of the response state.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP))
      else $error("result beat raised outside the response state");

   // The divider finishes only while the controller is waiting on it.
   assert property (@(posedge clock) disable iff (reset)
      (div_rsp.done |-> state_ff == S_DIV))
      else $error("divider finished while not awaited");

   // A successful free clears exactly one used bit of its row.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FREE_CHK && used_wr_en) |->
       ($countones(used_wr_data) + 1 == $countones(free_row))))
      else $error("free changed more than one used bit");

   // An allocation only writes its guard byte together with a used-map update.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIT && reg_wr_en) |-> used_wr_en))
      else $error("guard byte written without marking the slot used");

endmodule
